[design/glt_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph table lookup package
// Types, codes and constants that the glyph table modules share.
// ----------------------------------------------------------------------------
package glt_pkg;

    localparam int MAX_GLYPHS_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_SIZE   = 1'd1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_LAYOUT = 2'd2,
        ST_NO_ROOM   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_MONO  = 2'd0,
        MODE_GRAY4 = 2'd1,
        MODE_GRAY8 = 2'd2
    } t_depth;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_DISPATCH = 2'd1,
        S_PROBE    = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        code_point;
        logic [31:0]        in_bitmap_offset;
        logic [15:0]        in_bitmap_size;
        logic [7:0]         in_width;
        logic [7:0]         in_height;
        logic signed [7:0]  in_x_offset;
        logic signed [7:0]  in_y_offset;
        logic [7:0]         in_x_advance;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   found_index;
        logic [31:0]        out_bitmap_offset;
        logic [15:0]        out_bitmap_size;
        logic [7:0]         out_width;
        logic [7:0]         out_height;
        logic signed [7:0]  out_x_offset;
        logic signed [7:0]  out_y_offset;
        logic [7:0]         out_x_advance;
        logic               table_sorted;
    } t_result;

    typedef struct packed {
        logic [31:0]        cp;
        logic [31:0]        off;
        logic [15:0]        size;
        logic [7:0]         w;
        logic [7:0]         h;
        logic signed [7:0]  xo;
        logic signed [7:0]  yo;
        logic [7:0]         adv;
    } t_glyph;

endpackage

[design/glt_store.sv]
// ----------------------------------------------------------------------------
// Glyph record store
// Single write port, single registered read port record memory.
// ----------------------------------------------------------------------------
module glt_store #(
    parameter int DEPTH = glt_pkg::MAX_GLYPHS_DEF,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  glt_pkg::t_glyph  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output glt_pkg::t_glyph  o_rdata
);
    import glt_pkg::*;

    t_glyph r_mem [DEPTH];
    t_glyph r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/glt_check.sv]
// ----------------------------------------------------------------------------
// Glyph record check
// Checks a loaded record against the pixel depth and the bitmap area.
// ----------------------------------------------------------------------------
module glt_check (
    input  logic [1:0]       i_mode,
    input  logic [31:0]      i_area,
    input  glt_pkg::t_glyph  i_glyph,
    output logic             o_ok
);
    import glt_pkg::*;

    logic [8:0]  w_sum_mono;
    logic [8:0]  w_sum_gray;
    logic [7:0]  w_stride;
    logic        w_known;
    logic [15:0] w_need;
    logic [31:0] w_room;
    logic        w_empty_bad;
    logic        w_short;
    logic        w_off_bad;
    logic        w_size_bad;

    assign w_sum_mono = {1'b0, i_glyph.w} + 9'd7;
    assign w_sum_gray = {1'b0, i_glyph.w} + 9'd1;

    always_comb begin
        w_stride = '0;
        w_known  = 1'b1;
        case (t_depth'(i_mode))
            MODE_MONO:  w_stride = {2'b00, w_sum_mono[8:3]};
            MODE_GRAY4: w_stride = w_sum_gray[8:1];
            MODE_GRAY8: w_stride = i_glyph.w;
            default:    w_known  = 1'b0;
        endcase
    end

    assign w_need      = w_known ? 16'(w_stride) * 16'(i_glyph.h) : 16'd0;
    assign w_room      = i_area - i_glyph.off;
    assign w_empty_bad = ((i_glyph.w == 8'd0) || (i_glyph.h == 8'd0)) && (i_glyph.size != 16'd0);
    assign w_short     = (w_need != 16'd0) && (i_glyph.size < w_need);
    assign w_off_bad   = i_glyph.off > i_area;
    assign w_size_bad  = {16'd0, i_glyph.size} > w_room;
    assign o_ok        = !(w_empty_bad || w_short || w_off_bad || w_size_bad);

endmodule

[design/glyph_table_lookup_top.sv]
// ----------------------------------------------------------------------------
// Glyph table lookup
// Glyph metrics table with clear, load and codepoint lookup commands.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low, and its single
// result word is shown on o_result for exactly one cycle with o_done high,
// so the receiver must capture it then. Clear, load and unused commands are
// answered from the dispatch state; a lookup goes on to the probe state and
// reads one record per probe from the record memory, whose single read port
// sets the pace: a sorted table needs at most ceil(log2(n + 1)) probes, which
// is eleven for 1024 entries, and an unsorted table is scanned from index zero
// and needs up to n probes. The next command may be started in the cycle of
// the result strobe. Configuration writes are taken at any edge with i_cfg_we
// high and should be made only while the block is idle.
module glyph_table_lookup_top #(
    parameter int MAX_GLYPHS = glt_pkg::MAX_GLYPHS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  glt_pkg::t_cmd                 i_cmd,
    output logic                          o_busy,
    output logic                          o_done,
    output glt_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [glt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [glt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import glt_pkg::*;

    localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CW = $clog2(MAX_GLYPHS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_GLYPHS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [1:0]      r_mode;
    logic [31:0]     r_area;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [31:0]     r_prev, n_prev;
    logic            r_sorted, n_sorted;
    logic            r_bad, n_bad;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_mid, n_mid;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    t_glyph          w_new;
    t_glyph          w_rdata;
    logic            w_ok;
    logic            w_we;
    logic [AW-1:0]   w_raddr;
    logic [31:0]     w_cnt_ext;
    logic [31:0]     w_mid_ext;
    logic            w_eq;
    logic            w_less;
    logic [CW-1:0]   w_mid_inc;
    logic [CW-1:0]   w_mid_a;
    logic [CW-1:0]   w_mid_b;
    logic            w_empty_a;
    logic            w_empty_b;
    logic            w_empty_l;

    assign w_new.cp   = r_cmd.code_point;
    assign w_new.off  = r_cmd.in_bitmap_offset;
    assign w_new.size = r_cmd.in_bitmap_size;
    assign w_new.w    = r_cmd.in_width;
    assign w_new.h    = r_cmd.in_height;
    assign w_new.xo   = r_cmd.in_x_offset;
    assign w_new.yo   = r_cmd.in_y_offset;
    assign w_new.adv  = r_cmd.in_x_advance;

    glt_check u_check (
        .i_mode  (r_mode),
        .i_area  (r_area),
        .i_glyph (w_new),
        .o_ok    (w_ok)
    );

    glt_store #(
        .DEPTH (MAX_GLYPHS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_new),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Both successor probes are formed from registers; the compare only selects.
    assign w_eq      = w_rdata.cp == r_cmd.code_point;
    assign w_less    = r_cmd.code_point < w_rdata.cp;
    assign w_mid_inc = r_mid + CNT_ONE;
    assign w_mid_a   = r_lo + ((r_mid - r_lo) >> 1);
    assign w_mid_b   = w_mid_inc + ((r_hi - w_mid_inc) >> 1);
    assign w_empty_a = r_lo >= r_mid;
    assign w_empty_b = w_mid_inc >= r_hi;
    assign w_empty_l = w_mid_inc >= r_cnt;
    assign w_cnt_ext = 32'(r_cnt);
    assign w_mid_ext = 32'(r_mid);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_prev   = r_prev;
        n_sorted = r_sorted;
        n_bad    = r_bad;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_done   = 1'b0;
        n_res    = r_res;
        w_we     = 1'b0;
        w_raddr  = r_mid[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res              = '0;
                n_res.table_sorted = r_sorted;
                n_state            = S_IDLE;
                n_done             = 1'b1;
                case (t_op'(r_cmd.op))
                    OP_CLEAR: begin
                        n_cnt              = '0;
                        n_prev             = '0;
                        n_sorted           = 1'b1;
                        n_bad              = 1'b0;
                        n_res.table_sorted = 1'b1;
                    end
                    OP_LOAD: begin
                        if (r_cnt >= CNT_MAX) begin
                            n_res.status = ST_NO_ROOM;
                        end else begin
                            w_we   = 1'b1;
                            n_cnt  = r_cnt + CNT_ONE;
                            n_prev = r_cmd.code_point;
                            if (!w_ok) begin
                                n_bad = 1'b1;
                            end
                            if ((r_cnt != '0) && (r_cmd.code_point <= r_prev)) begin
                                n_sorted = 1'b0;
                            end
                            n_res.status            = w_ok ? ST_OK : ST_BAD_LAYOUT;
                            n_res.found_index       = w_cnt_ext[IDX_W-1:0];
                            n_res.out_bitmap_offset = w_new.off;
                            n_res.out_bitmap_size   = w_new.size;
                            n_res.out_width         = w_new.w;
                            n_res.out_height        = w_new.h;
                            n_res.out_x_offset      = w_new.xo;
                            n_res.out_y_offset      = w_new.yo;
                            n_res.out_x_advance     = w_new.adv;
                            n_res.table_sorted      = n_sorted;
                        end
                    end
                    OP_LOOKUP: begin
                        if (r_bad) begin
                            n_res.status = ST_BAD_LAYOUT;
                        end else if (r_cnt == '0) begin
                            n_res.status = ST_NOT_FOUND;
                        end else begin
                            n_done  = 1'b0;
                            n_state = S_PROBE;
                            n_lo    = '0;
                            n_hi    = r_cnt;
                            n_mid   = r_sorted ? (r_cnt >> 1) : '0;
                            w_raddr = n_mid[AW-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PROBE: begin
                n_res              = '0;
                n_res.table_sorted = r_sorted;
                if (w_eq) begin
                    n_res.status            = ST_OK;
                    n_res.found_index       = w_mid_ext[IDX_W-1:0];
                    n_res.out_bitmap_offset = w_rdata.off;
                    n_res.out_bitmap_size   = w_rdata.size;
                    n_res.out_width         = w_rdata.w;
                    n_res.out_height        = w_rdata.h;
                    n_res.out_x_offset      = w_rdata.xo;
                    n_res.out_y_offset      = w_rdata.yo;
                    n_res.out_x_advance     = w_rdata.adv;
                    n_done                  = 1'b1;
                    n_state                 = S_IDLE;
                end else if (r_sorted) begin
                    if (w_less) begin
                        n_hi  = r_mid;
                        n_mid = w_mid_a;
                        if (w_empty_a) begin
                            n_res.status = ST_NOT_FOUND;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        n_lo  = w_mid_inc;
                        n_mid = w_mid_b;
                        if (w_empty_b) begin
                            n_res.status = ST_NOT_FOUND;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                end else begin
                    n_mid = w_mid_inc;
                    if (w_empty_l) begin
                        n_res.status = ST_NOT_FOUND;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
                if (n_state == S_PROBE) begin
                    w_raddr = n_mid[AW-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_prev   <= '0;
            r_sorted <= 1'b1;
            r_bad    <= 1'b0;
            r_done   <= 1'b0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_mid    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_prev   <= n_prev;
            r_sorted <= n_sorted;
            r_bad    <= n_bad;
            r_done   <= n_done;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_mid    <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if ((r_state == S_IDLE) && i_start) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_area <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_DEPTH: r_mode <= i_cfg_wdata[1:0];
                CFG_AREA_SIZE:   r_area <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_DISPATCH) || ($past(r_state) == S_PROBE))
        else $error("Result word without a command in progress.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("Entry count exceeds the table depth.");

    a_probe_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_mid < r_cnt))
        else $error("Probe index outside the loaded entries.");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PROBE) && r_sorted) |-> ((r_lo <= r_mid) && (r_mid < r_hi)))
        else $error("Binary search probe outside its interval.");

    a_write_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_DISPATCH) && (r_cnt < CNT_MAX)))
        else $error("Record write outside a load with room.");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Glyph table lookup testbench
// Drives clear, load and lookup commands into the glyph table and checks
// every result word against a behavioral copy of the table that is updated
// at each accepted command. The run has a directed part at every pixel depth
// and bitmap area extreme, a completely filled sorted table with no idle
// cycles, and rounds of random sorted and unsorted tables with lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import glt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    t_cmd                  i_cmd = '0;
    logic                  o_busy;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    t_glyph      table_glyphs [MAX_GLYPHS_DEF];
    int unsigned table_entries = 0;
    logic [31:0] last_code_point = '0;
    logic        table_in_order = 1'b1;
    logic        table_corrupt = 1'b0;
    logic [1:0]  depth_mode = MODE_MONO;
    logic [31:0] area_bytes = '0;

    t_result     awaited_words [$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;

    glyph_table_lookup_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned bitmap_bytes(logic [7:0] w, logic [7:0] h);
        int unsigned wv;
        int unsigned hv;
        wv = 32'(w);
        hv = 32'(h);
        case (depth_mode)
            MODE_MONO:  return ((wv + 7) / 8) * hv;
            MODE_GRAY4: return ((wv + 1) / 2) * hv;
            MODE_GRAY8: return wv * hv;
            default:    return 0;
        endcase
    endfunction

    function automatic bit glyph_fits(t_glyph g);
        int unsigned need;
        need = bitmap_bytes(g.w, g.h);
        if ((g.w == 0 || g.h == 0) && g.size != 0) return 1'b0;
        if (need > 0 && 32'(g.size) < need) return 1'b0;
        if (g.off > area_bytes) return 1'b0;
        if (32'(g.size) > area_bytes - g.off) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_result table_response(t_cmd c);
        t_result     r;
        t_glyph      g;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int          found;
        r = '0;
        found = -1;
        case (c.op)
            OP_CLEAR: begin
                table_entries = 0;
                last_code_point = '0;
                table_in_order = 1'b1;
                table_corrupt = 1'b0;
            end
            OP_LOAD: begin
                if (table_entries >= MAX_GLYPHS_DEF) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    g.cp = c.code_point;
                    g.off = c.in_bitmap_offset;
                    g.size = c.in_bitmap_size;
                    g.w = c.in_width;
                    g.h = c.in_height;
                    g.xo = c.in_x_offset;
                    g.yo = c.in_y_offset;
                    g.adv = c.in_x_advance;
                    if (!glyph_fits(g)) begin
                        table_corrupt = 1'b1;
                        r.status = ST_BAD_LAYOUT;
                    end
                    if (table_entries > 0 && c.code_point <= last_code_point) begin
                        table_in_order = 1'b0;
                    end
                    last_code_point = c.code_point;
                    table_glyphs[table_entries] = g;
                    found = int'(table_entries);
                    table_entries++;
                end
            end
            OP_LOOKUP: begin
                if (table_corrupt) begin
                    r.status = ST_BAD_LAYOUT;
                end else begin
                    if (table_in_order) begin
                        lo = 0;
                        hi = table_entries;
                        while (lo < hi && found < 0) begin
                            mid = lo + (hi - lo) / 2;
                            if (table_glyphs[mid].cp == c.code_point) found = int'(mid);
                            else if (c.code_point < table_glyphs[mid].cp) hi = mid;
                            else lo = mid + 1;
                        end
                    end else begin
                        for (int i = 0; i < int'(table_entries) && found < 0; i++) begin
                            if (table_glyphs[i].cp == c.code_point) found = i;
                        end
                    end
                    if (found < 0) r.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        if (found >= 0) begin
            g = table_glyphs[found];
            r.found_index = IDX_W'(found);
            r.out_bitmap_offset = g.off;
            r.out_bitmap_size = g.size;
            r.out_width = g.w;
            r.out_height = g.h;
            r.out_x_offset = g.xo;
            r.out_y_offset = g.yo;
            r.out_x_advance = g.adv;
        end
        r.table_sorted = table_in_order;
        return r;
    endfunction

    function automatic t_cmd plain_cmd(t_op op);
        t_cmd c;
        c = '0;
        c.op = op;
        return c;
    endfunction

    function automatic t_cmd lookup_of(logic [31:0] cp);
        t_cmd c;
        c = plain_cmd(OP_LOOKUP);
        c.code_point = cp;
        return c;
    endfunction

    function automatic t_cmd glyph_cmd(t_op op, logic [31:0] cp, logic [31:0] off,
                                       logic [15:0] size, logic [7:0] w, logic [7:0] h,
                                       logic [7:0] xo, logic [7:0] yo, logic [7:0] adv);
        t_cmd c;
        c.op = op;
        c.code_point = cp;
        c.in_bitmap_offset = off;
        c.in_bitmap_size = size;
        c.in_width = w;
        c.in_height = h;
        c.in_x_offset = xo;
        c.in_y_offset = yo;
        c.in_x_advance = adv;
        return c;
    endfunction

    function automatic t_cmd noise_cmd(t_op op);
        return glyph_cmd(op, $urandom, $urandom, 16'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic t_cmd valid_load(logic [31:0] cp);
        t_cmd        c;
        int unsigned need;
        int unsigned room;
        int unsigned span;
        c = noise_cmd(OP_LOAD);
        c.code_point = cp;
        if ($urandom_range(0, 9) != 0) begin
            c.in_width = 8'($urandom_range(0, 24));
            c.in_height = 8'($urandom_range(0, 24));
        end
        need = bitmap_bytes(c.in_width, c.in_height);
        if (need > area_bytes) c.in_height = '0;
        if (c.in_width == 0 || c.in_height == 0) begin
            c.in_bitmap_size = '0;
        end else begin
            room = area_bytes - need;
            if (room > 64) room = 64;
            if (room > 65535 - need) room = 65535 - need;
            c.in_bitmap_size = 16'(need + $urandom_range(0, room));
        end
        span = area_bytes - 32'(c.in_bitmap_size);
        c.in_bitmap_offset = (span == 32'hFFFF_FFFF) ? $urandom : $urandom % (span + 1);
        return c;
    endfunction

    function automatic t_cmd probe_cmd(bit hit);
        t_cmd        c;
        logic [31:0] near;
        c = noise_cmd(OP_LOOKUP);
        if (table_entries != 0) begin
            near = table_glyphs[$urandom_range(0, table_entries - 1)].cp;
            if (hit) c.code_point = near;
            else if ($urandom_range(0, 1) == 1) c.code_point = near + 32'd1;
            else if ($urandom_range(0, 1) == 1) c.code_point = near - 32'd1;
        end
        return c;
    endfunction

    task automatic send_word(input t_cmd c);
        if (!steady && $urandom_range(0, 99) < 14) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        awaited_words.push_back(table_response(c));
        if (c.op != OP_NONE) words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_start <= 1'b0;
        if (awaited_words.size() != 0) begin
            while (awaited_words.size() != 0) @(posedge i_clk);
            repeat (2) @(posedge i_clk);
        end
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PIXEL_DEPTH) depth_mode = data[1:0];
        else area_bytes = data;
        @(posedge i_clk);
    endtask

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_words.size() == 0) begin
                mismatches++;
                $error("result word with no command outstanding");
            end else begin
                want = awaited_words.pop_front();
                compare_field("status", 32'(want.status), 32'(o_result.status));
                compare_field("found_index", 32'(want.found_index), 32'(o_result.found_index));
                compare_field("out_bitmap_offset", want.out_bitmap_offset,
                              o_result.out_bitmap_offset);
                compare_field("out_bitmap_size", 32'(want.out_bitmap_size),
                              32'(o_result.out_bitmap_size));
                compare_field("out_width", 32'(want.out_width), 32'(o_result.out_width));
                compare_field("out_height", 32'(want.out_height), 32'(o_result.out_height));
                compare_field("out_x_offset", {24'd0, want.out_x_offset},
                              {24'd0, o_result.out_x_offset});
                compare_field("out_y_offset", {24'd0, want.out_y_offset},
                              {24'd0, o_result.out_y_offset});
                compare_field("out_x_advance", 32'(want.out_x_advance),
                              32'(o_result.out_x_advance));
                compare_field("table_sorted", 32'(want.table_sorted),
                              32'(o_result.table_sorted));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed_cases();
        send_word(lookup_of(32'd0));
        send_word(plain_cmd(OP_NONE));
        send_word(glyph_cmd(OP_LOAD, 32'd0, 32'd0, 16'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'd0));
        send_word(glyph_cmd(OP_LOAD, 32'd5, 32'd0, 16'd1, 8'd8, 8'd1, 8'h01, 8'hFF, 8'd4));
        send_word(lookup_of(32'd0));
        send_word(plain_cmd(OP_CLEAR));

        write_reg(CFG_AREA_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_PIXEL_DEPTH, CFG_DATA_W'(MODE_MONO));
        send_word(glyph_cmd(OP_LOAD, 32'd0, 32'hFFFF_FFFF - 32'd8160, 16'd8160,
                            8'd255, 8'd255, 8'h80, 8'h7F, 8'd255));
        send_word(glyph_cmd(OP_LOAD, 32'h7FFF_FFFF, 32'd0, 16'd4, 8'd9, 8'd2,
                            8'h7F, 8'h80, 8'd0));
        send_word(glyph_cmd(OP_LOAD, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 8'd1, 8'd1,
                            8'hFF, 8'h01, 8'd1));
        send_word(lookup_of(32'h7FFF_FFFF));
        send_word(lookup_of(32'hFFFF_FFFF));
        send_word(lookup_of(32'd1));
        send_word(glyph_cmd(OP_LOAD, 32'h10, 32'd100, 16'd2, 8'd16, 8'd1, 8'h00, 8'h00, 8'd9));
        send_word(lookup_of(32'h10));
        send_word(lookup_of(32'hFFFF_FFFE));
        send_word(glyph_cmd(OP_LOAD, 32'h20, 32'd0, 16'd1, 8'd3, 8'd0, 8'h00, 8'h00, 8'd3));
        send_word(lookup_of(32'h10));
        send_word(plain_cmd(OP_CLEAR));

        write_reg(CFG_PIXEL_DEPTH, CFG_DATA_W'(MODE_GRAY4));
        write_reg(CFG_AREA_SIZE, 32'd100);
        send_word(glyph_cmd(OP_LOAD, 32'd1, 32'd0, 16'd7, 8'd3, 8'd4, 8'h00, 8'h00, 8'd3));
        send_word(plain_cmd(OP_CLEAR));
        send_word(glyph_cmd(OP_LOAD, 32'd2, 32'd92, 16'd8, 8'd3, 8'd4, 8'h00, 8'h00, 8'd3));
        send_word(glyph_cmd(OP_LOAD, 32'd3, 32'd101, 16'd1, 8'd1, 8'd1, 8'h00, 8'h00, 8'd1));
        send_word(plain_cmd(OP_CLEAR));

        write_reg(CFG_PIXEL_DEPTH, CFG_DATA_W'(MODE_GRAY8));
        write_reg(CFG_AREA_SIZE, 32'd1000);
        send_word(glyph_cmd(OP_LOAD, 32'd4, 32'd900, 16'd100, 8'd10, 8'd10, 8'h00, 8'h00, 8'd10));
        send_word(glyph_cmd(OP_LOAD, 32'd5, 32'd0, 16'd99, 8'd10, 8'd10, 8'h00, 8'h00, 8'd10));
        send_word(plain_cmd(OP_CLEAR));

        write_reg(CFG_PIXEL_DEPTH, CFG_DATA_W'(MODE_UNDEFINED));
        send_word(glyph_cmd(OP_LOAD, 32'd6, 32'd0, 16'd1, 8'd200, 8'd200, 8'h00, 8'h00, 8'd200));
        send_word(glyph_cmd(OP_LOAD, 32'd7, 32'd0, 16'd3, 8'd0, 8'd5, 8'h00, 8'h00, 8'd0));
    endtask

    task automatic test_full_table();
        longint unsigned cp;
        write_reg(CFG_PIXEL_DEPTH, CFG_DATA_W'(MODE_GRAY8));
        write_reg(CFG_AREA_SIZE, 32'hFFFF_FFFF);
        steady = 1'b1;
        send_word(plain_cmd(OP_CLEAR));
        cp = longint'($urandom_range(0, 255));
        repeat (MAX_GLYPHS_DEF) begin
            send_word(valid_load(32'(cp)));
            cp += $urandom_range(1, 4096);
        end
        steady = 1'b0;
        send_word(noise_cmd(OP_LOAD));
        send_word(valid_load(32'(cp)));
        send_word(lookup_of(table_glyphs[0].cp));
        send_word(lookup_of(table_glyphs[MAX_GLYPHS_DEF-1].cp));
        repeat (40) send_word(probe_cmd($urandom_range(0, 1) == 1));
    endtask

    task automatic test_random_tables(int unsigned quota);
        int unsigned     goal;
        int unsigned     n;
        int unsigned     bad_at;
        int unsigned     stride_max;
        int unsigned     base;
        longint unsigned cp;
        longint unsigned top;
        bit              ordered;
        goal = words_sent + quota;
        while (words_sent < goal) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_PIXEL_DEPTH, CFG_DATA_W'($urandom_range(0, 3)));
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_AREA_SIZE, '0);
                    1: write_reg(CFG_AREA_SIZE, $urandom_range(1, 255));
                    2: write_reg(CFG_AREA_SIZE, $urandom_range(256, 1 << 20));
                    3: write_reg(CFG_AREA_SIZE, $urandom);
                    default: write_reg(CFG_AREA_SIZE, 32'hFFFF_FFFF);
                endcase
            end
            send_word(plain_cmd(OP_CLEAR));
            ordered = $urandom_range(0, 9) < 7;
            n = (ordered && $urandom_range(0, 5) == 0) ? $urandom_range(49, 160)
                                                       : $urandom_range(0, 48);
            bad_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n) : n;
            stride_max = 1 << $urandom_range(0, 20);
            top = 64'hFFFF_FFFF - longint'(n) * stride_max;
            cp = longint'($urandom) % (top + 1);
            base = $urandom;
            for (int i = 0; i < int'(n); i++) begin
                if ($urandom_range(0, 29) == 0) send_word(noise_cmd(OP_NONE));
                if (i == int'(bad_at)) begin
                    send_word(noise_cmd(OP_LOAD));
                end else if (ordered) begin
                    send_word(valid_load(32'(cp)));
                    cp += $urandom_range(1, stride_max);
                end else begin
                    send_word(valid_load(base + $urandom_range(0, 2 * n)));
                end
            end
            repeat ($urandom_range(1, 24)) send_word(probe_cmd($urandom_range(0, 9) < 6));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_table();
        test_random_tables(330);
        i_start <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
